### rtl/core/ckct_pkg.sv
package ckct_pkg;

  localparam int XY_W    = 16;
  localparam int COLOR_W = 31;
  localparam int FUNC_W  = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_GET    = 2'd0,
    FUNC_SET    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_NOP    = 2'd3   // unused code, answered as a no-op
  } func_e;

  // Search token that walks the cell chain, one cell per cycle
  typedef struct packed {
    logic               vld;
    logic               hit;
    logic [COLOR_W-1:0] color;       // color of the matching entry
    logic [COLOR_W-1:0] last_color;  // color of the last filled entry
  } tok_t;

  // Broadcast command from the controller to every cell
  typedef struct packed {
    logic clr;      // drop the match marks of the previous search
    logic we;       // write one entry this cycle
    logic use_sel;  // 1: write the marked entry, 0: write the entry at count
  } cmd_t;

endpackage

### rtl/core/ckct_cell.sv
module ckct_cell #(
  parameter int IDX        = 0,
  parameter int COORD_BITS = 16,
  parameter int CNT_W      = 7
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [CNT_W-1:0]             count_i,
  input  logic [COORD_BITS-1:0]        key_x_i,
  input  logic [COORD_BITS-1:0]        key_y_i,
  input  ckct_pkg::cmd_t               cmd_i,
  input  logic [COORD_BITS-1:0]        wr_x_i,
  input  logic [COORD_BITS-1:0]        wr_y_i,
  input  logic [ckct_pkg::COLOR_W-1:0] wr_color_i,
  input  ckct_pkg::tok_t               tok_i,
  input  logic [COORD_BITS-1:0]        last_x_i,
  input  logic [COORD_BITS-1:0]        last_y_i,
  output ckct_pkg::tok_t               tok_o,
  output logic [COORD_BITS-1:0]        last_x_o,
  output logic [COORD_BITS-1:0]        last_y_o
);
  import ckct_pkg::*;

  logic [COORD_BITS-1:0] ex_q, ey_q;
  logic [COLOR_W-1:0]    ec_q;
  logic                  sel_q, sel_d;
  tok_t                  tok_q, tok_d;
  logic [COORD_BITS-1:0] lx_q, ly_q, lx_d, ly_d;
  logic                  live, is_last, match, we;

  // entries at or beyond the fill count are never compared or read
  assign live    = CNT_W'(IDX) < count_i;
  assign is_last = CNT_W'(IDX + 1) == count_i;
  assign match   = tok_i.vld && live && (ex_q == key_x_i) && (ey_q == key_y_i);
  assign we      = cmd_i.we && (cmd_i.use_sel ? sel_q : (CNT_W'(IDX) == count_i));

  always_comb begin
    tok_d = tok_i;
    lx_d  = last_x_i;
    ly_d  = last_y_i;
    if (match) begin
      tok_d.hit   = 1'b1;
      tok_d.color = ec_q;
    end
    if (tok_i.vld && is_last) begin
      tok_d.last_color = ec_q;
      lx_d             = ex_q;
      ly_d             = ey_q;
    end
    sel_d = cmd_i.clr ? 1'b0 : (sel_q | match);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
      tok_q <= '0;
    end else begin
      sel_q <= sel_d;
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lx_q <= lx_d;
    ly_q <= ly_d;
    if (we) begin
      ex_q <= wr_x_i;
      ey_q <= wr_y_i;
      ec_q <= wr_color_i;
    end
  end

  assign tok_o    = tok_q;
  assign last_x_o = lx_q;
  assign last_y_o = ly_q;

endmodule

### rtl/core/coordinate_keyed_color_table_top.sv
// Channel  | Handshake              | Beat
// ---------+------------------------+---------------------------------------------
// command  | start_i, busy_o        | func_i, x_i, y_i, color_i
// result   | result_valid_o strobe  | found_o, hit_color_o, changed_o, full_res_o,
//          |                        | dirty_o
//
// A get/set/remove answers with the result strobe once the search token has
// walked the chain of CAPACITY entry cells, one cell per cycle.
// A command with key bit COORD_BITS-1 set or an unused func answers next cycle.
// busy_o drops in the result cycle, so the next command can be taken then.
// Reset empties the table and clears dirty; no clearing pass is needed.
// The receiver cannot stall: each result is shown for one cycle only.
module coordinate_keyed_color_table_top #(
  parameter int CAPACITY   = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [ckct_pkg::FUNC_W-1:0]  func_i,
  input  logic signed [ckct_pkg::XY_W-1:0] x_i,
  input  logic signed [ckct_pkg::XY_W-1:0] y_i,
  input  logic [ckct_pkg::COLOR_W-1:0] color_i,
  output logic                         result_valid_o,
  output logic                         found_o,
  output logic [ckct_pkg::COLOR_W-1:0] hit_color_o,
  output logic                         changed_o,
  output logic                         full_res_o,
  output logic                         dirty_o
);
  import ckct_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EXT_W = (COORD_BITS > XY_W) ? COORD_BITS : XY_W;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_e;

  state_e                state_q;
  logic [FUNC_W-1:0]     func_q;
  logic [COORD_BITS-1:0] key_x_q, key_y_q;
  logic [COLOR_W-1:0]    color_q;
  logic                  inject_q;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  dirty_q, dirty_d;

  logic [EXT_W-1:0]      x_ext, y_ext;
  logic [COORD_BITS-1:0] key_x, key_y;
  logic                  accept, nop, fin;

  cmd_t                  cmd;
  logic [COORD_BITS-1:0] wr_x, wr_y;
  logic [COLOR_W-1:0]    wr_color;
  logic                  r_found, r_changed, r_full;
  logic [COLOR_W-1:0]    r_color;

  tok_t                  tok   [CAPACITY+1];
  logic [COORD_BITS-1:0] lx    [CAPACITY+1];
  logic [COORD_BITS-1:0] ly    [CAPACITY+1];

  // key is the low COORD_BITS of the zero-extended field
  assign x_ext  = EXT_W'($unsigned(x_i));
  assign y_ext  = EXT_W'($unsigned(y_i));
  assign key_x  = x_ext[COORD_BITS-1:0];
  assign key_y  = y_ext[COORD_BITS-1:0];

  assign accept = start_i && !busy_o;
  assign nop    = key_x[COORD_BITS-1] || key_y[COORD_BITS-1] ||
                  !((func_i == FUNC_GET) || (func_i == FUNC_SET) ||
                    (func_i == FUNC_REMOVE));
  assign fin    = (state_q == ST_SEARCH) && tok[CAPACITY].vld;

  assign tok[0].vld        = inject_q;
  assign tok[0].hit        = 1'b0;
  assign tok[0].color      = '0;
  assign tok[0].last_color = '0;
  assign lx[0]             = '0;
  assign ly[0]             = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ckct_cell #(
      .IDX        (i),
      .COORD_BITS (COORD_BITS),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .count_i    (count_q),
      .key_x_i    (key_x_q),
      .key_y_i    (key_y_q),
      .cmd_i      (cmd),
      .wr_x_i     (wr_x),
      .wr_y_i     (wr_y),
      .wr_color_i (wr_color),
      .tok_i      (tok[i]),
      .last_x_i   (lx[i]),
      .last_y_i   (ly[i]),
      .tok_o      (tok[i+1]),
      .last_x_o   (lx[i+1]),
      .last_y_o   (ly[i+1])
    );
  end

  always_comb begin
    cmd       = '0;
    cmd.clr   = accept;
    wr_x      = key_x_q;
    wr_y      = key_y_q;
    wr_color  = color_q;
    count_d   = count_q;
    r_found   = tok[CAPACITY].hit;
    r_color   = '0;
    r_changed = 1'b0;
    r_full    = 1'b0;
    if (fin) begin
      case (func_q)
        FUNC_GET: begin
          if (tok[CAPACITY].hit) r_color = tok[CAPACITY].color;
        end
        FUNC_SET: begin
          if (tok[CAPACITY].hit) begin
            if (tok[CAPACITY].color != color_q) begin
              cmd.we      = 1'b1;
              cmd.use_sel = 1'b1;
              r_changed   = 1'b1;
            end
          end else if (count_q < CNT_W'(CAPACITY)) begin
            cmd.we    = 1'b1;
            count_d   = count_q + 1'b1;
            r_changed = 1'b1;
          end else begin
            r_full = 1'b1;
          end
        end
        FUNC_REMOVE: begin
          // last entry moves into the freed slot
          if (tok[CAPACITY].hit) begin
            cmd.we      = 1'b1;
            cmd.use_sel = 1'b1;
            wr_x        = lx[CAPACITY];
            wr_y        = ly[CAPACITY];
            wr_color    = tok[CAPACITY].last_color;
            count_d     = count_q - 1'b1;
            r_changed   = 1'b1;
          end
        end
        default: ;
      endcase
    end
    dirty_d = dirty_q | r_changed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      busy_o         <= 1'b0;
      inject_q       <= 1'b0;
      count_q        <= '0;
      dirty_q        <= 1'b0;
      func_q         <= '0;
      key_x_q        <= '0;
      key_y_q        <= '0;
      color_q        <= '0;
      result_valid_o <= 1'b0;
      found_o        <= 1'b0;
      hit_color_o    <= '0;
      changed_o      <= 1'b0;
      full_res_o     <= 1'b0;
      dirty_o        <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      inject_q       <= 1'b0;
      count_q        <= count_d;
      dirty_q        <= dirty_d;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            func_q  <= func_i;
            key_x_q <= key_x;
            key_y_q <= key_y;
            color_q <= color_i;
            if (nop) begin
              result_valid_o <= 1'b1;
              found_o        <= 1'b0;
              hit_color_o    <= '0;
              changed_o      <= 1'b0;
              full_res_o     <= 1'b0;
              dirty_o        <= dirty_q;
            end else begin
              inject_q <= 1'b1;
              busy_o   <= 1'b1;
              state_q  <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (fin) begin
            result_valid_o <= 1'b1;
            found_o        <= r_found;
            hit_color_o    <= r_color;
            changed_o      <= r_changed;
            full_res_o     <= r_full;
            dirty_o        <= dirty_d;
            busy_o         <= 1'b0;
            state_q        <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          busy_o  <= 1'b0;
        end
      endcase
    end
  end

endmodule

### rtl/core/ckct_chk.sv
module ckct_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic                         result_valid_o,
  input logic                         found_o,
  input logic [ckct_pkg::COLOR_W-1:0] hit_color_o,
  input logic                         changed_o,
  input logic                         full_res_o,
  input logic                         dirty_o
);
  import ckct_pkg::*;

  // a change always leaves the table dirty
  a_changed_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && changed_o |-> dirty_o)
    else $error("changed result without dirty");

  // a dropped insert is a miss that changed nothing
  a_full_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && full_res_o |-> !found_o && !changed_o)
    else $error("full_res with found or changed");

  // a nonzero color only comes from a hit
  a_color_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (hit_color_o != '0) |-> found_o)
    else $error("hit_color without found");

  // the result beat always lands with the block ready again
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result while busy");

  // dirty is sticky until reset
  a_dirty_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(dirty_o) |-> dirty_o)
    else $error("dirty cleared");

endmodule

bind coordinate_keyed_color_table_top ckct_chk u_ckct_chk (.*);

### dv/tb_coordinate_keyed_color_table_top.sv
module tb_coordinate_keyed_color_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ckct_pkg::*;

  localparam int CAPACITY   = 64;
  localparam int COORD_BITS = 16;
  localparam int POOL_SIZE  = 80;
  localparam int CLK_HALF   = 4;
  localparam int LIMIT      = 400000;

  typedef logic [ckct_pkg::FUNC_W-1:0]  func_t;
  typedef logic [ckct_pkg::XY_W-1:0]    coord_t;
  typedef logic [ckct_pkg::COLOR_W-1:0] color_t;

  typedef struct {
    func_t       func;
    coord_t      x;
    coord_t      y;
    color_t      color;
    int unsigned gap;
    bit          drain;  // hold off until every result has come back
  } color_cmd_t;

  typedef struct packed {
    logic   found;
    color_t color;
    logic   changed;
    logic   full;
    logic   dirty;
  } color_resp_t;

  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   start_i = 1'b0;
  func_t  func_i = FUNC_GET;
  coord_t x_i = '0;
  coord_t y_i = '0;
  color_t color_i = '0;
  logic   busy_o;
  logic   result_valid_o;
  logic   found_o;
  color_t hit_color_o;
  logic   changed_o;
  logic   full_res_o;
  logic   dirty_o;

  coordinate_keyed_color_table_top #(
    .CAPACITY  (CAPACITY),
    .COORD_BITS(COORD_BITS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .func_i        (func_i),
    .x_i           (x_i),
    .y_i           (y_i),
    .color_i       (color_i),
    .result_valid_o(result_valid_o),
    .found_o       (found_o),
    .hit_color_o   (hit_color_o),
    .changed_o     (changed_o),
    .full_res_o    (full_res_o),
    .dirty_o       (dirty_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // ---------------------------------------------------------------- table model
  coord_t tbl_x     [CAPACITY];
  coord_t tbl_y     [CAPACITY];
  color_t tbl_color [CAPACITY];
  int     tbl_fill  = 0;
  bit     tbl_dirty = 1'b0;

  function automatic color_resp_t table_apply(color_cmd_t c);
    color_resp_t r;
    int slot;
    r = '0;
    if (!c.x[COORD_BITS-1] && !c.y[COORD_BITS-1] && c.func != FUNC_NOP) begin
      slot = tbl_fill;
      for (int i = 0; i < tbl_fill; i++)
        if (slot == tbl_fill && tbl_x[i] == c.x && tbl_y[i] == c.y) slot = i;
      r.found = (slot < tbl_fill);
      case (c.func)
        FUNC_GET: begin
          if (r.found) r.color = tbl_color[slot];
        end
        FUNC_SET: begin
          if (r.found) begin
            if (tbl_color[slot] != c.color) begin
              tbl_color[slot] = c.color;
              r.changed = 1'b1;
            end
          end else if (tbl_fill < CAPACITY) begin
            tbl_x[tbl_fill]     = c.x;
            tbl_y[tbl_fill]     = c.y;
            tbl_color[tbl_fill] = c.color;
            tbl_fill++;
            r.changed = 1'b1;
          end else begin
            r.full = 1'b1;
          end
        end
        default: begin
          // remove: the last entry moves into the freed slot
          if (r.found) begin
            tbl_x[slot]     = tbl_x[tbl_fill-1];
            tbl_y[slot]     = tbl_y[tbl_fill-1];
            tbl_color[slot] = tbl_color[tbl_fill-1];
            tbl_fill--;
            r.changed = 1'b1;
          end
        end
      endcase
      if (r.changed) tbl_dirty = 1'b1;
    end
    r.dirty = tbl_dirty;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus
  color_cmd_t  cmd_q[$];
  color_resp_t resp_q[$];
  coord_t      pool_x [POOL_SIZE];
  coord_t      pool_y [POOL_SIZE];
  int unsigned seq_idx = 0;

  function automatic void add_cmd(func_t f, coord_t x, coord_t y, color_t col,
                                  int unsigned gap, bit drain);
    color_cmd_t c;
    c.func  = f;
    c.x     = x;
    c.y     = y;
    c.color = col;
    c.gap   = gap;
    c.drain = drain;
    cmd_q.push_back(c);
  endfunction

  // a small palette makes same-color sets common
  function automatic color_t pick_color();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 31'h7FFF_FFFF;
      2:       return 31'h2AAA_AAAA;
      3:       return 31'h5555_5555;
      default: return color_t'($urandom);
    endcase
  endfunction

  function automatic int unsigned draw_gap(bit burst);
    if (burst || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 15);
  endfunction

  // thresholds are cumulative percentages: set, then get, then remove, rest is noise
  function automatic void add_random(int p_set, int p_get, int p_rem, bit seq_set,
                                     bit burst, bit drain);
    int unsigned roll, k;
    coord_t nx, ny;
    func_t f;
    roll = $urandom_range(0, 99);
    k    = $urandom_range(0, POOL_SIZE-1);
    nx   = pool_x[k];
    ny   = pool_y[k];
    if (roll < p_set) begin
      if (seq_set) begin
        nx = pool_x[seq_idx % POOL_SIZE];
        ny = pool_y[seq_idx % POOL_SIZE];
        seq_idx++;
      end
      f = FUNC_SET;
    end else if (roll < p_get) begin
      f = FUNC_GET;
    end else if (roll < p_rem) begin
      f = FUNC_REMOVE;
    end else begin
      case ($urandom_range(0, 3))
        0: nx = coord_t'($urandom) | 16'h8000;
        1: ny = coord_t'($urandom) | 16'h8000;
        2: begin
          nx = coord_t'($urandom) | 16'h8000;
          ny = coord_t'($urandom) | 16'h8000;
        end
        default: ;
      endcase
      f = (!nx[COORD_BITS-1] && !ny[COORD_BITS-1]) ? FUNC_NOP : func_t'($urandom_range(0, 3));
    end
    add_cmd(f, nx, ny, pick_color(), draw_gap(burst), drain);
  endfunction

  // ---------------------------------------------------------------- driver
  color_cmd_t  cur;
  bit          launch_pend = 1'b0;
  int unsigned gap_cnt = 0;
  int unsigned n_accepted = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i     <= 1'b0;
      func_i      <= FUNC_GET;
      x_i         <= '0;
      y_i         <= '0;
      color_i     <= '0;
      launch_pend <= 1'b0;
      gap_cnt     <= 0;
    end else begin
      if (start_i && !busy_o) begin
        resp_q.push_back(table_apply(cur));
        n_accepted++;
      end
      if (!start_i || !busy_o) begin
        if (launch_pend) begin
          if (gap_cnt != 0) begin
            gap_cnt <= gap_cnt - 1;
            start_i <= 1'b0;
          end else begin
            start_i     <= 1'b1;
            launch_pend <= 1'b0;
          end
        end else if (cmd_q.size() != 0 && !(cmd_q[0].drain && resp_q.size() != 0)) begin
          cur     = cmd_q.pop_front();
          func_i  <= cur.func;
          x_i     <= cur.x;
          y_i     <= cur.y;
          color_i <= cur.color;
          if (cur.gap == 0) begin
            start_i <= 1'b1;
          end else begin
            start_i     <= 1'b0;
            gap_cnt     <= cur.gap - 1;
            launch_pend <= 1'b1;
          end
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  int unsigned fail_cnt = 0;
  int unsigned n_checked = 0;
  int unsigned n_hit = 0;
  int unsigned n_change = 0;
  int unsigned n_full = 0;

  always @(posedge clk_i) begin : mon
    color_resp_t want;
    if (rst_ni && result_valid_o) begin
      if (resp_q.size() == 0) begin
        $error("result beat with no command outstanding");
        fail_cnt++;
      end else begin
        want = resp_q.pop_front();
        n_checked++;
        n_hit    += want.found;
        n_change += want.changed;
        n_full   += want.full;
        if (found_o !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found_o);
          fail_cnt++;
        end
        if (hit_color_o !== want.color) begin
          $error("hit_color: expected 0x%08h, got 0x%08h", want.color, hit_color_o);
          fail_cnt++;
        end
        if (changed_o !== want.changed) begin
          $error("changed: expected %0d, got %0d", want.changed, changed_o);
          fail_cnt++;
        end
        if (full_res_o !== want.full) begin
          $error("full_res: expected %0d, got %0d", want.full, full_res_o);
          fail_cnt++;
        end
        if (dirty_o !== want.dirty) begin
          $error("dirty: expected %0d, got %0d", want.dirty, dirty_o);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  int unsigned cyc_cnt = 0;

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cyc_cnt, resp_q.size());
      $display("coordinate_keyed_color_table_top verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin : seq
    rst_ni = 1'b0;

    // distinct keys: the low y bits carry the pool index
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_x[i] = {1'b0, 15'($urandom)};
      pool_y[i] = {1'b0, 8'($urandom), 7'(i)};
    end

    // directed: empty table, extremes, same-color set, swap on remove, ignored items
    add_cmd(FUNC_GET,    16'h0000, 16'h0000, pick_color(),   draw_gap(0), 1'b0);
    add_cmd(FUNC_REMOVE, 16'h0000, 16'h0000, pick_color(),   draw_gap(0), 1'b0);
    add_cmd(FUNC_SET,    16'h0000, 16'h0000, 31'h0,          draw_gap(0), 1'b0);
    add_cmd(FUNC_SET,    16'h0000, 16'h0000, 31'h0,          draw_gap(0), 1'b0);
    add_cmd(FUNC_GET,    16'h0000, 16'h0000, 31'h7FFF_FFFF,  draw_gap(0), 1'b0);
    add_cmd(FUNC_SET,    16'h7FFF, 16'h7FFF, 31'h7FFF_FFFF,  draw_gap(0), 1'b0);
    add_cmd(FUNC_GET,    16'h7FFF, 16'h7FFF, 31'h0,          draw_gap(0), 1'b0);
    add_cmd(FUNC_SET,    16'h0005, 16'h0009, 31'h2AAA_AAAA,  draw_gap(0), 1'b0);
    add_cmd(FUNC_GET,    16'h0009, 16'h0005, pick_color(),   draw_gap(0), 1'b0);
    add_cmd(FUNC_GET,    16'h0005, 16'h0008, pick_color(),   draw_gap(0), 1'b0);
    add_cmd(FUNC_SET,    16'h0000, 16'h0000, 31'h5555_5555,  draw_gap(0), 1'b0);
    add_cmd(FUNC_GET,    16'h0000, 16'h0000, pick_color(),   draw_gap(0), 1'b0);
    add_cmd(FUNC_SET,    16'hFFFF, 16'h0003, 31'h1234_5678,  draw_gap(0), 1'b0);
    add_cmd(FUNC_SET,    16'h0003, 16'h8000, 31'h1234_5678,  draw_gap(0), 1'b0);
    add_cmd(FUNC_GET,    16'h8000, 16'h8000, pick_color(),   draw_gap(0), 1'b0);
    add_cmd(FUNC_NOP,    16'h0000, 16'h0000, 31'h7FFF_FFFF,  draw_gap(0), 1'b0);
    add_cmd(FUNC_NOP,    16'hFFFF, 16'hFFFF, 31'h7FFF_FFFF,  draw_gap(0), 1'b0);
    add_cmd(FUNC_REMOVE, 16'h0000, 16'h0000, pick_color(),   draw_gap(0), 1'b0);
    add_cmd(FUNC_GET,    16'h0005, 16'h0009, pick_color(),   draw_gap(0), 1'b0);
    add_cmd(FUNC_GET,    16'h0000, 16'h0000, pick_color(),   draw_gap(0), 1'b0);
    add_cmd(FUNC_REMOVE, 16'h0005, 16'h0009, pick_color(),   draw_gap(0), 1'b0);
    add_cmd(FUNC_REMOVE, 16'h7FFF, 16'h7FFF, pick_color(),   draw_gap(0), 1'b0);
    add_cmd(FUNC_REMOVE, 16'h7FFF, 16'h7FFF, pick_color(),   draw_gap(0), 1'b0);
    add_cmd(FUNC_GET,    16'h7FFF, 16'h7FFF, pick_color(),   draw_gap(0), 1'b0);

    // fill past capacity with sequential keys, then drain, then a mixed load
    for (int i = 0; i < 170; i++) add_random(75, 90, 95, 1'b1, 1'b0, i == 0);
    for (int i = 0; i < 130; i++) add_random(15, 40, 95, 1'b0, 1'b0, i == 0);
    for (int i = 0; i < 110; i++) add_random(35, 65, 95, 1'b0, i < 55, i == 0 || i == 55);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (cmd_q.size() != 0 || start_i || launch_pend || resp_q.size() != 0)
      @(negedge clk_i);
    repeat (CAPACITY + 8) @(posedge clk_i);

    $display("%0d commands sent, %0d results checked: %0d key hits, %0d table changes,",
             n_accepted, n_checked, n_hit, n_change);
    $display("%0d inserts dropped on a full table, %0d entries left", n_full, tbl_fill);
    if (fail_cnt == 0) begin
      $display("coordinate_keyed_color_table_top verification clean");
    end else begin
      $display("coordinate_keyed_color_table_top verification failed");
    end
    $finish;
  end

endmodule
